@@ src/ste_pkg.sv @@
// Shared types, sizes and codes for the sorted table engine.
// No dependencies; imported by every module of the block.
package ste_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_entry;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [IDX_W-1:0]   t_index;
    typedef logic [1:0]         t_op;
    typedef logic [1:0]         t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_DELETE = 2'd1;
    localparam t_op OP_SEARCH = 2'd2;
    localparam t_op OP_CLEAR  = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_MISSING = 2'd2;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic compare;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

endpackage

@@ src/ste_cell.sv @@
// One table slot: holds an entry, compares it with the request value and
// moves data to or from its neighbors. Depends on ste_pkg.
module ste_cell
    import ste_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_is_insert,
    input  t_entry    i_value,
    input  t_count    i_count,
    input  t_index    i_index,
    input  t_entry    i_prev_entry,
    input  logic      i_prev_lt,
    input  logic      i_prev_eq,
    input  t_entry    i_next_entry,
    output t_entry    o_entry,
    output logic      o_lt,
    output logic      o_eq,
    output logic      o_hit,
    output logic      o_tail
);

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   w_active;

    assign w_active = t_count'(i_index) < i_count;
    assign o_tail   = (t_count'(i_index) + t_count'(1)) == i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            r_lt <= w_active && (r_entry < i_value);
            r_eq <= w_active && (r_entry == i_value);
        end
        // cells at or past the insert/delete point move; the rest hold
        if (i_ctl.shift_up && !r_lt) begin
            r_entry <= i_prev_lt ? i_value : i_prev_entry;
        end else if (i_ctl.shift_down && !r_lt) begin
            r_entry <= i_next_entry;
        end
    end

    // sorted table: smaller entries come first, equal ones are contiguous,
    // so the boundary is found from the left neighbor alone
    assign o_hit   = i_is_insert ? (!r_lt && i_prev_lt) : (r_eq && !i_prev_eq);
    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

@@ src/ste_select.sv @@
// Encodes the one-hot hit flags into a position and picks the tail entry.
// Depends on ste_pkg.
module ste_select
    import ste_pkg::*;
(
    input  logic [CAPACITY-1:0] i_hit,
    input  logic [CAPACITY-1:0] i_tail,
    input  t_entry              i_entry [CAPACITY],
    output t_count              o_position,
    output t_entry              o_largest
);

    always_comb begin
        o_position = '0;
        o_largest  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_hit[i]) begin
                o_position = o_position | t_count'(i + 1);
            end
            if (i_tail[i]) begin
                o_largest = o_largest | i_entry[i];
            end
        end
    end

endmodule

@@ src/sorted_table_engine.sv @@
// Sorted table engine: ascending table of signed values in a row of cells.
// Result: o_valid is registered from the update state, which follows the compare state.
// A new transaction can be accepted in the update state; busy is high only in the compare state.
// The receiver cannot stall; o_valid is a one-cycle strobe.
// Reset (i_rst_n, synchronous, active low) empties the table and idles the control.
// Depends on ste_pkg, ste_cell, ste_select.
module sorted_table_engine
    import ste_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_op     i_operation,
    input  t_entry  i_value,
    output logic    o_valid,
    output t_status o_status,
    output t_count  o_position,
    output t_count  o_entry_count,
    output t_entry  o_smallest,
    output t_entry  o_largest,
    output logic    o_is_empty,
    output logic    o_is_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    t_op        r_op;
    t_entry     r_value;
    t_count     r_count, n_count;
    t_status    r_status, n_status;
    t_count     r_pos, n_pos;
    logic       r_valid;

    t_cell_ctl  w_ctl;
    logic       w_is_insert;
    logic       w_accept;
    logic       w_full;
    logic       w_found;
    t_count     w_enc_pos;
    t_entry     w_tail_entry;

    t_entry              w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_tail;

    assign busy        = (r_state == S_CMP);
    assign w_accept    = start && !busy;
    assign w_full      = (r_count == t_count'(CAPACITY));
    assign w_found     = |w_hit;
    assign w_is_insert = (r_op == OP_INSERT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = w_accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.compare    = (r_state == S_CMP);
        w_ctl.shift_up   = 1'b0;
        w_ctl.shift_down = 1'b0;
        n_count          = r_count;
        n_status         = ST_OK;
        n_pos            = '0;
        if (r_state == S_UPD) begin
            unique case (r_op)
                OP_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.shift_up = 1'b1;
                        n_pos          = w_enc_pos;
                        n_count        = r_count + t_count'(1);
                    end
                end
                OP_DELETE: begin
                    if (w_found) begin
                        w_ctl.shift_down = 1'b1;
                        n_pos            = w_enc_pos;
                        n_count          = r_count - t_count'(1);
                    end else begin
                        n_status = ST_MISSING;
                    end
                end
                OP_SEARCH: begin
                    if (w_found) begin
                        n_pos = w_enc_pos;
                    end else begin
                        n_status = ST_MISSING;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= (r_state == S_UPD);
        end
        if (w_accept) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ste_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_is_insert  (w_is_insert),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_index      (t_index'(g)),
            .i_prev_entry (g == 0 ? t_entry'(0) : w_entry[(g == 0) ? 0 : g - 1]),
            .i_prev_lt    (g == 0 ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_prev_eq    (g == 0 ? 1'b0 : w_eq[(g == 0) ? 0 : g - 1]),
            .i_next_entry (g == CAPACITY - 1 ? t_entry'(0)
                                             : w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry      (w_entry[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g]),
            .o_hit        (w_hit[g]),
            .o_tail       (w_tail[g])
        );
    end

    ste_select u_select (
        .i_hit      (w_hit),
        .i_tail     (w_tail),
        .i_entry    (w_entry),
        .o_position (w_enc_pos),
        .o_largest  (w_tail_entry)
    );

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_entry_count = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_is_full     = w_full;
    assign o_smallest    = (r_count == '0) ? t_entry'(0) : w_entry[0];
    assign o_largest     = (r_count == '0) ? t_entry'(0) : w_tail_entry;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count above capacity");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start compare");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |->
            (o_is_full && o_position == '0))
        else $error("dropped insert with table not full");
`endif

endmodule
